### rtl/fpe_pkg.sv
// ----------------------------------------------------------------------------
// Frustum plane extractor package
// Shared types, codes and default constants for the plane extractor.
// ----------------------------------------------------------------------------
package fpe_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int NUM_PLANES     = 6;
    localparam int SQRT_STEPS     = 31;
    localparam int SUM_W          = 62;
    localparam int ROOT_W         = 31;
    localparam int TERM_W         = 30;

    typedef enum logic [1:0] {
        CMD_LOAD_PROJ = 2'd0,
        CMD_LOAD_VIEW = 2'd1,
        CMD_COMPUTE   = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_PROJ,
        OP_LOAD_VIEW,
        OP_PP,
        OP_ACC,
        OP_PLANE,
        OP_SHIFT,
        OP_SQ,
        OP_SQRT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_PP,
        ST_MUL_ACC,
        ST_PLANE,
        ST_CHECK,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_DIV_END,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [5:0] mac;
        logic [1:0] pp;
        logic [2:0] plane;
        logic [1:0] sel;
        logic       first;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        logic norm_done;
        logic zero_normal;
        logic out_free;
    } dp_stat_t;

endpackage

### rtl/fpe_ctrl.sv
// ----------------------------------------------------------------------------
// Frustum plane extractor controller
// Sequences loads, the matrix product and the per-plane normalization steps.
// ----------------------------------------------------------------------------
module fpe_ctrl #(
    parameter int FRAC_BITS  = fpe_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = fpe_pkg::DATA_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        command,
    input  fpe_pkg::dp_stat_t stat,
    output fpe_pkg::dp_cmd_t  cmd
);
    import fpe_pkg::*;

    localparam int NW = DATA_WIDTH + 1 + FRAC_BITS;
    localparam int CW = $clog2(NW);

    ctrl_state_t    state_reg, state_next;
    logic [5:0]     mac_reg, mac_next;
    logic [2:0]     plane_reg, plane_next;
    logic [1:0]     sel_reg, sel_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mac_reg   <= '0;
            plane_reg <= '0;
            sel_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mac_reg   <= mac_next;
            plane_reg <= plane_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mac_next   = mac_reg;
        plane_next = plane_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.mac    = mac_reg;
        cmd.pp     = cnt_reg[1:0];
        cmd.plane  = plane_reg;
        cmd.sel    = sel_reg;
        cmd.first  = 1'b0;
        cmd.last   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (cmd_t'(command))
                        CMD_LOAD_PROJ: cmd.op = OP_LOAD_PROJ;
                        CMD_LOAD_VIEW: cmd.op = OP_LOAD_VIEW;
                        CMD_COMPUTE:
                        begin
                            mac_next   = '0;
                            cnt_next   = '0;
                            plane_next = '0;
                            state_next = ST_MUL_PP;
                        end
                        default: cmd.op = OP_NONE;
                    endcase
                end
            end
            ST_MUL_PP:
            begin
                cmd.op   = OP_PP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    cnt_next   = '0;
                    state_next = ST_MUL_ACC;
                end
            end
            ST_MUL_ACC:
            begin
                cmd.op    = OP_ACC;
                cmd.first = (mac_reg[1:0] == 2'd0);
                cmd.last  = (mac_reg[1:0] == 2'd3);
                mac_next  = mac_reg + 1'b1;
                state_next = (mac_reg == 6'd63) ? ST_PLANE : ST_MUL_PP;
            end
            ST_PLANE:
            begin
                cmd.op     = OP_PLANE;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = stat.zero_normal ? ST_EMIT : ST_NORM;
            end
            ST_NORM:
            begin
                if (stat.norm_done)
                begin
                    sel_next   = '0;
                    state_next = ST_SQ;
                end
                else
                begin
                    cmd.op = OP_SHIFT;
                end
            end
            ST_SQ:
            begin
                cmd.op    = OP_SQ;
                cmd.first = (sel_reg == 2'd0);
                sel_next  = sel_reg + 1'b1;
                if (sel_reg == 2'd2)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.op    = OP_SQRT;
                cmd.first = (cnt_reg == '0);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CW'(SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    sel_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.op    = OP_DIV_STEP;
                cmd.first = (cnt_reg == '0);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END:
            begin
                cmd.op   = OP_DIV_END;
                sel_next = sel_reg + 1'b1;
                state_next = (sel_reg == 2'd3) ? ST_EMIT : ST_DIV;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op = OP_EMIT;
                    if (plane_reg == 3'(NUM_PLANES - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        plane_next = plane_reg + 1'b1;
                        state_next = ST_PLANE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### rtl/fpe_dp.sv
// ----------------------------------------------------------------------------
// Frustum plane extractor datapath
// Matrix stores, multiply-accumulate, plane forming, square root, divider
// and the result register.
// ----------------------------------------------------------------------------
module fpe_dp #(
    parameter int FRAC_BITS  = fpe_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = fpe_pkg::DATA_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  fpe_pkg::dp_cmd_t         cmd,
    output fpe_pkg::dp_stat_t        stat,
    input  logic [3:0]               element_index,
    input  logic signed [31:0]       element_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               plane_index,
    output logic signed [31:0]       normal_x,
    output logic signed [31:0]       normal_y,
    output logic signed [31:0]       normal_z,
    output logic signed [31:0]       plane_offset,
    output logic                     degenerate,
    output logic                     last_plane
);
    import fpe_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int H  = (DW + 1) / 2;
    localparam int PW = 4 * H;
    localparam int AW = PW + 2;
    localparam int VW = DW + 1;
    localparam int NW = VW + F;
    localparam int OW = (DW < FIELD_W) ? DW : FIELD_W;
    localparam int XW = (DW > FIELD_W) ? DW : FIELD_W;
    localparam int SW = $clog2(VW);

    logic signed [DW-1:0] proj_reg [16];
    logic signed [DW-1:0] view_reg [16];
    logic signed [DW-1:0] comp_reg [16];
    logic [PW-1:0]        prod_reg;
    logic                 neg_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [VW-1:0] v_reg [4];
    logic [VW-1:0]        m_reg;
    logic [VW-1:0]        msh_reg;
    logic [SW-1:0]        s_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     src_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [ROOT_W+1:0]    rem_reg;
    logic [NW-1:0]        dvd_reg;
    logic [ROOT_W-1:0]    drem_reg;
    logic [FIELD_W-1:0]   res_reg [4];
    logic                 out_valid_reg;
    logic [2:0]           plane_index_reg;
    logic [FIELD_W-1:0]   nx_reg, ny_reg, nz_reg, off_reg;
    logic                 degen_reg, last_reg;

    // Load value saturation
    logic signed [XW-1:0] ld_ext, ld_max, ld_min;
    logic signed [DW-1:0] ld_val;

    assign ld_ext = XW'(element_value);
    assign ld_max = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    assign ld_min = ~ld_max;

    always_comb
    begin
        if (ld_ext > ld_max)
            ld_val = ld_max[DW-1:0];
        else if (ld_ext < ld_min)
            ld_val = ld_min[DW-1:0];
        else
            ld_val = ld_ext[DW-1:0];
    end

    // Partial product multiplier
    logic [1:0]           k_idx, r_idx, c_idx;
    logic signed [DW-1:0] mul_a, mul_b;
    logic [DW-1:0]        ua, ub;
    logic [H-1:0]         a_part, b_part;
    logic [2*H-1:0]       partial;
    logic [PW-1:0]        pp_shifted;

    assign k_idx  = cmd.mac[1:0];
    assign r_idx  = cmd.mac[3:2];
    assign c_idx  = cmd.mac[5:4];
    assign mul_a  = proj_reg[{k_idx, r_idx}];
    assign mul_b  = view_reg[{c_idx, k_idx}];
    assign ua     = mul_a[DW-1] ? (~mul_a + 1'b1) : mul_a;
    assign ub     = mul_b[DW-1] ? (~mul_b + 1'b1) : mul_b;
    assign a_part = cmd.pp[0] ? H'(ua >> H) : ua[H-1:0];
    assign b_part = cmd.pp[1] ? H'(ub >> H) : ub[H-1:0];
    assign partial = (2*H)'(a_part) * (2*H)'(b_part);

    always_comb
    begin
        case (cmd.pp)
            2'd0:    pp_shifted = PW'(partial);
            2'd3:    pp_shifted = PW'(partial) << (2 * H);
            default: pp_shifted = PW'(partial) << H;
        endcase
    end

    // Accumulate and saturate
    logic signed [PW:0]   sp, sp_sh;
    logic signed [AW-1:0] acc_next, acc_max, acc_min;
    logic signed [DW-1:0] acc_sat;

    assign sp       = neg_reg ? -$signed({1'b0, prod_reg}) : $signed({1'b0, prod_reg});
    assign sp_sh    = sp >>> F;
    assign acc_next = (cmd.first ? '0 : acc_reg) + AW'(sp_sh);
    assign acc_max  = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    assign acc_min  = ~acc_max;

    always_comb
    begin
        if (acc_next > acc_max)
            acc_sat = acc_max[DW-1:0];
        else if (acc_next < acc_min)
            acc_sat = acc_min[DW-1:0];
        else
            acc_sat = acc_next[DW-1:0];
    end

    // Plane forming
    logic signed [VW-1:0] v_new [4];
    logic [VW-1:0]        v_mag [3];
    logic [VW-1:0]        m_new;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            if (cmd.plane[0])
                v_new[j] = VW'(comp_reg[{2'(j), 2'd3}]) - VW'(comp_reg[{2'(j), cmd.plane[2:1]}]);
            else
                v_new[j] = VW'(comp_reg[{2'(j), 2'd3}]) + VW'(comp_reg[{2'(j), cmd.plane[2:1]}]);
        end
        for (int j = 0; j < 3; j++)
        begin
            v_mag[j] = v_new[j][VW-1] ? (~v_new[j] + 1'b1) : v_new[j];
        end
        m_new = v_mag[0];
        if (v_mag[1] > m_new)
            m_new = v_mag[1];
        if (v_mag[2] > m_new)
            m_new = v_mag[2];
    end

    // Selected component magnitude
    logic signed [VW-1:0] v_sel;
    logic [VW-1:0]        v_sel_mag;

    assign v_sel     = v_reg[cmd.sel];
    assign v_sel_mag = v_sel[VW-1] ? (~v_sel + 1'b1) : v_sel;

    // Sum of squares
    logic [TERM_W-1:0]   term;
    logic [2*TERM_W-1:0] term_sq;
    logic [SUM_W-1:0]    sum_next;

    assign term     = TERM_W'(v_sel_mag >> s_reg);
    assign term_sq  = (2*TERM_W)'(term) * (2*TERM_W)'(term);
    assign sum_next = (cmd.first ? '0 : sum_reg) + SUM_W'(term_sq);

    // Square root, two bits per step
    logic [SUM_W-1:0]  src_in;
    logic [ROOT_W+1:0] rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [ROOT_W+3:0] sq_r2, sq_trial;
    logic              sq_ge;

    assign src_in   = cmd.first ? sum_reg : src_reg;
    assign rem_in   = cmd.first ? '0 : rem_reg;
    assign root_in  = cmd.first ? '0 : root_reg;
    assign sq_r2    = {rem_in, src_in[SUM_W-1:SUM_W-2]};
    assign sq_trial = (ROOT_W+4)'({root_in, 2'b01});
    assign sq_ge    = (sq_r2 >= sq_trial);

    // Restoring divider, one quotient bit per step
    logic [NW-1:0]     dvd_in;
    logic [ROOT_W-1:0] drem_in;
    logic [ROOT_W:0]   dv_r2;
    logic              dv_ge;

    assign dvd_in  = cmd.first ? (NW'(v_sel_mag) << F) : dvd_reg;
    assign drem_in = cmd.first ? '0 : drem_reg;
    assign dv_r2   = {drem_in, dvd_in[NW-1]};
    assign dv_ge   = (dv_r2 >= {1'b0, root_reg});

    // Final scale and saturation
    logic [NW-1:0]        quo_sh, lim, mcl;
    logic signed [OW-1:0] res_ow;
    logic                 res_neg;

    assign quo_sh  = dvd_reg >> s_reg;
    assign lim     = NW'(1) << (OW - 1);
    assign res_neg = v_sel[VW-1];

    always_comb
    begin
        if (quo_sh >= lim)
            mcl = res_neg ? lim : (lim - 1'b1);
        else
            mcl = quo_sh;
        res_ow = res_neg ? OW'(~mcl + 1'b1) : OW'(mcl);
    end

    // Status
    assign stat.norm_done   = ((msh_reg >> TERM_W) == '0);
    assign stat.zero_normal = (m_reg == '0);
    assign stat.out_free    = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                proj_reg[i] <= '0;
                view_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD_PROJ: proj_reg[element_index] <= ld_val;
                OP_LOAD_VIEW: view_reg[element_index] <= ld_val;
                default:      ;
            endcase
            if (cmd.op == OP_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_PP:
            begin
                prod_reg <= (cmd.pp == 2'd0) ? pp_shifted : (prod_reg + pp_shifted);
                neg_reg  <= mul_a[DW-1] ^ mul_b[DW-1];
            end
            OP_ACC:
            begin
                acc_reg <= acc_next;
                if (cmd.last)
                    comp_reg[cmd.mac[5:2]] <= acc_sat;
            end
            OP_PLANE:
            begin
                for (int j = 0; j < 4; j++)
                    v_reg[j] <= v_new[j];
                m_reg   <= m_new;
                msh_reg <= m_new;
                s_reg   <= '0;
            end
            OP_SHIFT:
            begin
                msh_reg <= msh_reg >> 1;
                s_reg   <= s_reg + 1'b1;
            end
            OP_SQ:
            begin
                sum_reg <= sum_next;
            end
            OP_SQRT:
            begin
                src_reg <= src_in << 2;
                if (sq_ge)
                begin
                    rem_reg  <= (ROOT_W+2)'(sq_r2 - sq_trial);
                    root_reg <= {root_in[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= (ROOT_W+2)'(sq_r2);
                    root_reg <= {root_in[ROOT_W-2:0], 1'b0};
                end
            end
            OP_DIV_STEP:
            begin
                dvd_reg  <= {dvd_in[NW-2:0], dv_ge};
                drem_reg <= dv_ge ? ROOT_W'(dv_r2 - {1'b0, root_reg}) : ROOT_W'(dv_r2);
            end
            OP_DIV_END:
            begin
                res_reg[cmd.sel] <= FIELD_W'(res_ow);
            end
            OP_EMIT:
            begin
                plane_index_reg <= cmd.plane;
                last_reg        <= (cmd.plane == 3'(NUM_PLANES - 1));
                degen_reg       <= (m_reg == '0);
                if (m_reg == '0)
                begin
                    nx_reg  <= '0;
                    ny_reg  <= '0;
                    nz_reg  <= '0;
                    off_reg <= '0;
                end
                else
                begin
                    nx_reg  <= res_reg[0];
                    ny_reg  <= res_reg[1];
                    nz_reg  <= res_reg[2];
                    off_reg <= res_reg[3];
                end
            end
            default: ;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign plane_index  = plane_index_reg;
    assign normal_x     = nx_reg;
    assign normal_y     = ny_reg;
    assign normal_z     = nz_reg;
    assign plane_offset = off_reg;
    assign degenerate   = degen_reg;
    assign last_plane   = last_reg;

endmodule

### rtl/frustum_plane_extractor.sv
// ----------------------------------------------------------------------------
// Frustum plane extractor
// Loads projection and view matrices and emits six normalized frustum planes.
// ----------------------------------------------------------------------------
// A load request writes one projection or view element. A compute request
// multiplies the matrices with one half-width partial product per cycle,
// then handles each plane with the shared square-root and divider units:
// it forms the plane, shifts it to normalize, sums the squares, takes the
// root and divides the four components by it, then emits the plane. The
// normalizing shift is at most DATA_WIDTH - 29 bits. A plane with a zero
// normal skips the root and divides. Results wait in an output register,
// and new requests are taken once the previous compute is done.
// ----------------------------------------------------------------------------
module frustum_plane_extractor #(
    parameter int FRAC_BITS  = fpe_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = fpe_pkg::DATA_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [3:0]         element_index,
    input  logic signed [31:0] element_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         plane_index,
    output logic signed [31:0] normal_x,
    output logic signed [31:0] normal_y,
    output logic signed [31:0] normal_z,
    output logic signed [31:0] plane_offset,
    output logic               degenerate,
    output logic               last_plane
);
    import fpe_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    fpe_ctrl #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .stat     (stat),
        .cmd      (cmd)
    );

    fpe_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .element_index (element_index),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .plane_index   (plane_index),
        .normal_x      (normal_x),
        .normal_y      (normal_y),
        .normal_z      (normal_z),
        .plane_offset  (plane_offset),
        .degenerate    (degenerate),
        .last_plane    (last_plane)
    );

endmodule

### tb/sv/frustum_plane_extractor_test.sv
// ----------------------------------------------------------------------------
// Frustum plane extractor testbench
// Loads projection and view matrices, issues compute requests and checks the
// six normalized planes of each compute against a fixed-point predictor.
// ----------------------------------------------------------------------------
module frustum_plane_extractor_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fpe_pkg::*;

    typedef struct {
        logic [1:0]  command;
        logic [3:0]  index;
        logic [31:0] value;
        bit          drain;
    } request_t;

    typedef struct {
        logic [2:0]  plane;
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
        logic [31:0] offset;
        logic        degenerate;
        logic        last;
    } plane_t;

    localparam int FB = FRAC_BITS_DEF;
    localparam int DW = DATA_WIDTH_DEF;
    localparam int OW = (DW < 32) ? DW : 32;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] command;
    logic [3:0] element_index;
    logic signed [31:0] element_value;
    logic out_valid;
    logic out_ready;
    logic [2:0] plane_index;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] plane_offset;
    logic degenerate;
    logic last_plane;

    request_t pending_requests[$];
    plane_t expected_planes[$];
    longint projection_matrix[16];
    longint view_matrix[16];
    int errors;
    int send_gap;
    int stall_count;
    bit stimulus_done;

    frustum_plane_extractor dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .element_index(element_index),
        .element_value(element_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .plane_index(plane_index),
        .normal_x(normal_x),
        .normal_y(normal_y),
        .normal_z(normal_z),
        .plane_offset(plane_offset),
        .degenerate(degenerate),
        .last_plane(last_plane)
    );

    function automatic longint clamp_signed(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [31:0] normalize(longint v, longint unsigned q, int s);
        longint unsigned a;
        longint unsigned qi;
        longint unsigned r;
        longint unsigned lim;
        longint unsigned m;
        longint unsigned num;
        a = magnitude(v);
        qi = a / q;
        r = a % q;
        lim = 64'd1 << (OW - 1);
        if ((qi >> (OW + s - FB)) != 0)
            m = lim;
        else
        begin
            num = (qi << FB) + ((r << FB) / q);
            m = num >> s;
            if (m > lim) m = lim;
        end
        if (v >= 0 && m == lim) m = lim - 1;
        if (v < 0) m = 64'd0 - m;
        return m[31:0];
    endfunction

    task automatic predict_planes();
        longint product[16];
        longint acc;
        longint v[4];
        longint unsigned m;
        longint unsigned sum;
        longint unsigned q;
        longint unsigned t;
        longint a;
        longint b;
        int s;
        int row;
        plane_t pl;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                    acc += (projection_matrix[k * 4 + r] * view_matrix[c * 4 + k]) >>> FB;
                product[c * 4 + r] = clamp_signed(acc, DW);
            end
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            row = p / 2;
            m = 0;
            for (int j = 0; j < 4; j++)
            begin
                a = product[j * 4 + 3];
                b = product[j * 4 + row];
                v[j] = (p % 2 == 1) ? a - b : a + b;
            end
            for (int j = 0; j < 3; j++)
                if (magnitude(v[j]) > m) m = magnitude(v[j]);
            pl.plane = 3'(p);
            pl.last = (p == NUM_PLANES - 1);
            if (m == 0)
            begin
                pl.nx = 0;
                pl.ny = 0;
                pl.nz = 0;
                pl.offset = 0;
                pl.degenerate = 1'b1;
            end
            else
            begin
                s = 0;
                while ((m >> s) >= (64'd1 << 30)) s++;
                sum = 0;
                for (int j = 0; j < 3; j++)
                begin
                    t = magnitude(v[j]) >> s;
                    sum += t * t;
                end
                q = int_sqrt(sum);
                pl.nx = normalize(v[0], q, s);
                pl.ny = normalize(v[1], q, s);
                pl.nz = normalize(v[2], q, s);
                pl.offset = normalize(v[3], q, s);
                pl.degenerate = 1'b0;
            end
            expected_planes.push_back(pl);
        end
    endtask

    task automatic apply_request(request_t rq);
        longint val;
        val = clamp_signed(longint'($signed(rq.value)), DW);
        case (rq.command)
            CMD_LOAD_PROJ: projection_matrix[rq.index] = val;
            CMD_LOAD_VIEW: view_matrix[rq.index] = val;
            CMD_COMPUTE: predict_planes();
            default: ;
        endcase
    endtask

    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] random_element();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_request(logic [1:0] cmd, logic [3:0] idx, logic [31:0] value,
                                 bit drain);
        request_t rq;
        rq.command = cmd;
        rq.index = idx;
        rq.value = value;
        rq.drain = drain;
        pending_requests.push_back(rq);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        errors = 0;
        stimulus_done = 1'b0;
        for (int i = 0; i < 16; i++)
        begin
            projection_matrix[i] = 0;
            view_matrix[i] = 0;
        end
        // Directed part: zero matrices give degenerate planes, then identity
        // and extreme elements, then the ignored command.
        queue_request(CMD_COMPUTE, 4'd15, 32'hFFFF_FFFF, 1'b0);
        for (int i = 0; i < 4; i++)
        begin
            queue_request(CMD_LOAD_PROJ, 4'(i * 5), 32'h0001_0000, 1'b0);
            queue_request(CMD_LOAD_VIEW, 4'(i * 5), 32'h0001_0000, 1'b0);
        end
        queue_request(CMD_COMPUTE, 4'd0, 32'h0, 1'b1);
        queue_request(CMD_LOAD_PROJ, 4'd3, 32'h8000_0000, 1'b0);
        queue_request(CMD_LOAD_VIEW, 4'd12, 32'h7FFF_FFFF, 1'b0);
        queue_request(CMD_LOAD_PROJ, 4'd15, 32'h7FFF_FFFF, 1'b0);
        queue_request(CMD_UNUSED, 4'd15, 32'h7FFF_FFFF, 1'b0);
        queue_request(CMD_COMPUTE, 4'd0, 32'h0, 1'b0);
        queue_request(CMD_UNUSED, 4'd10, 32'h5555_AAAA, 1'b0);
        queue_request(CMD_COMPUTE, 4'd5, 32'hAAAA_5555, 1'b0);
        // Random part: runs of two to twenty random loads or unused commands, each followed by a compute.
        while (pending_requests.size() < 330)
        begin
            int loads;
            loads = $urandom_range(2, 20);
            for (int i = 0; i < loads; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    queue_request(CMD_UNUSED, 4'($urandom), $urandom, 1'b0);
                else
                    queue_request(2'($urandom_range(0, 1)), 4'($urandom), random_element(),
                                  1'b0);
            end
            queue_request(CMD_COMPUTE, 4'($urandom), $urandom, $urandom_range(0, 7) == 0);
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= CMD_LOAD_PROJ;
            element_index <= '0;
            element_value <= '0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                apply_request('{command, element_index, element_value, 1'b0});
            if (send_gap > 0 || pending_requests.size() == 0 ||
                (pending_requests[0].drain && expected_planes.size() != 0))
            begin
                in_valid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
                if (pending_requests.size() == 0 && in_valid) stimulus_done <= 1'b1;
            end
            else
            begin
                request_t rq;
                rq = pending_requests.pop_front();
                in_valid <= 1'b1;
                command <= rq.command;
                element_index <= rq.index;
                element_value <= rq.value;
                send_gap <= random_gap();
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_planes.size() == 0)
                begin
                    $display("%0t: unexpected plane %0d", $time, plane_index);
                    errors++;
                end
                else
                begin
                    plane_t e;
                    e = expected_planes.pop_front();
                    if (e.plane !== plane_index || e.nx !== normal_x ||
                        e.ny !== normal_y || e.nz !== normal_z ||
                        e.offset !== plane_offset || e.degenerate !== degenerate ||
                        e.last !== last_plane)
                    begin
                        $display("%0t: expected %0d %h %h %h %h %b %b", $time, e.plane,
                                 e.nx, e.ny, e.nz, e.offset, e.degenerate, e.last);
                        $display("%0t: actual   %0d %h %h %h %h %b %b", $time,
                                 plane_index, normal_x, normal_y, normal_z,
                                 plane_offset, degenerate, last_plane);
                        errors++;
                    end
                end
            end
            if (stall_count > 0)
            begin
                out_ready <= 1'b0;
                stall_count <= stall_count - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_count <= random_gap();
            end
        end
    end

    initial
    begin
        wait (stimulus_done);
        wait (expected_planes.size() == 0);
        repeat (3000) @(posedge clk);
        if (errors == 0 && expected_planes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/fpe_pkg.sv
rtl/fpe_ctrl.sv
rtl/fpe_dp.sv
rtl/frustum_plane_extractor.sv
tb/sv/frustum_plane_extractor_test.sv
